// File: hdl/sst_pkg.sv
// shared types and constants for the sql statement tokenizer
// no dependencies; used by sst_lex, sst_outq and sql_statement_tokenizer_core
package sst_pkg;

    // most result items that one input byte can cause
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // lexer mode between bytes
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_NUM   = 3'd2,
        MODE_LT    = 3'd3,
        MODE_GT    = 3'd4,
        MODE_BANG  = 3'd5,
        MODE_STR   = 3'd6,
        MODE_STRQ  = 3'd7
    } lex_mode_t;

    // token kind codes as seen on tok_kind
    typedef enum logic [2:0] {
        KIND_PUNCT = 3'd0,
        KIND_CMP   = 3'd1,
        KIND_STR   = 3'd2,
        KIND_NUM   = 3'd3,
        KIND_IDENT = 3'd4,
        KIND_END   = 3'd5,
        KIND_ERR   = 3'd6
    } tok_kind_t;

    // error codes
    localparam logic ERR_UNEXPECTED = 1'b0;
    localparam logic ERR_UNTERM     = 1'b1;

    // characters with a meaning to the lexer
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // one result item
    typedef struct packed {
        logic [7:0] tbyte;
        tok_kind_t  kind;
        logic       first;
        logic       last;
        logic       err;
        logic       done;
    } tok_item_t;

    // result items of one input byte, handed from lexer to output queue
    typedef struct packed {
        logic                              valid;
        logic [CNT_W-1:0]                  cnt;
        tok_item_t [MAX_RESULTS-1:0]       items;
    } tok_bundle_t;

    // lexer state carried from byte to byte
    typedef struct packed {
        lex_mode_t  mode;
        logic [7:0] held_byte;
        tok_kind_t  held_kind;
        logic       held_valid;
        logic       held_first;
        logic       semi_held;
        logic       err_sink;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        mode:       MODE_IDLE,
        held_byte:  8'h00,
        held_kind:  KIND_PUNCT,
        held_valid: 1'b0,
        held_first: 1'b0,
        semi_held:  1'b0,
        err_sink:   1'b0
    };

endpackage

// File: hdl/sql_statement_tokenizer_core.sv
// top level of the sql statement tokenizer
// depends on sst_pkg, sst_lex and sst_outq
//
// Lexes SQL text arriving one byte per request (is_last on the statement's
// final byte) and returns token bytes one per request, each with a kind,
// first/last marks, an error code and stmt_done on the closing end item.
// A byte is accepted every cycle as long as each byte yields at most one
// result and out_ready stays high; a byte that yields two or three results
// (a flushed token plus a punctuation mark, an error, the end item) holds
// the input until the result register has drained, which it does one item
// per cycle while out_ready is high. The first result of a byte passes
// through the input register, where the lexer step runs, and then the
// result register, from which it can be taken. A trailing
// semicolon of a statement is swallowed;
// after an unexpected character or unterminated string an error item is
// given and the rest of the statement is skipped up to its end item.
module sql_statement_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    // byte stream in
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    // token stream out
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] tok_byte,
    output logic [2:0] tok_kind,
    output logic       tok_first,
    output logic       tok_last,
    output logic       err_code,
    output logic       stmt_done
);

    // results of one byte, from the lexer step into the result register
    sst_pkg::tok_bundle_t push;
    // result register can take a new bundle this cycle
    logic                 q_free;

    // input register, lexer state and per-byte step
    sst_lex u_lex (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .is_last  (is_last),
        .q_free   (q_free),
        .push     (push)
    );

    // result register, one item out per request
    sst_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_free    (q_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tok_byte  (tok_byte),
        .tok_kind  (tok_kind),
        .tok_first (tok_first),
        .tok_last  (tok_last),
        .err_code  (err_code),
        .stmt_done (stmt_done)
    );

endmodule

// File: hdl/sst_lex.sv
// input register, lexer state and the per-byte lexing step
// depends on sst_pkg; feeds result bundles to sst_outq
module sst_lex (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                is_last,
    input  logic                q_free,
    output sst_pkg::tok_bundle_t push
);

    typedef struct packed {
        sst_pkg::lex_state_t  nxt;
        sst_pkg::tok_bundle_t res;
    } lex_out_t;

    logic [7:0]          byte_reg;
    logic                last_reg;
    logic                inv_reg;
    logic                inv_next;
    sst_pkg::lex_state_t st_reg;
    sst_pkg::lex_state_t st_next;
    sst_pkg::lex_state_t st_step;
    sst_pkg::tok_bundle_t step_res;
    logic                advance;
    logic                in_take;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic sst_pkg::tok_item_t make_tok(
        input logic [7:0]         b,
        input sst_pkg::tok_kind_t k,
        input logic               f,
        input logic               l,
        input logic               e,
        input logic               d
    );
        sst_pkg::tok_item_t t;
        t.tbyte = b;
        t.kind  = k;
        t.first = f;
        t.last  = l;
        t.err   = e;
        t.done  = d;
        return t;
    endfunction

    function automatic void put(inout sst_pkg::tok_bundle_t bd, input sst_pkg::tok_item_t it);
        bd.items[bd.cnt] = it;
        bd.cnt = bd.cnt + sst_pkg::CNT_W'(1);
    endfunction

    function automatic void hold(
        inout sst_pkg::lex_state_t st,
        input logic [7:0]          b,
        input sst_pkg::tok_kind_t  k,
        input logic                f
    );
        st.held_byte  = b;
        st.held_kind  = k;
        st.held_first = f;
        st.held_valid = 1'b1;
    endfunction

    // flush the held byte with its last mark now known
    function automatic void release_held(
        inout sst_pkg::lex_state_t  st,
        inout sst_pkg::tok_bundle_t bd,
        input logic                 l
    );
        if (st.held_valid)
        begin
            put(bd, make_tok(st.held_byte, st.held_kind, st.held_first, l, 1'b0, 1'b0));
            st.held_valid = 1'b0;
        end
    endfunction

    function automatic void raise_error(
        inout sst_pkg::lex_state_t  st,
        inout sst_pkg::tok_bundle_t bd,
        input logic [7:0]           b,
        input logic                 code
    );
        st.held_valid = 1'b0;
        st.semi_held  = 1'b0;
        st.mode       = sst_pkg::MODE_IDLE;
        st.err_sink   = 1'b1;
        put(bd, make_tok(b, sst_pkg::KIND_ERR, 1'b1, 1'b1, code, 1'b0));
    endfunction

    function automatic lex_out_t lex_step(
        input sst_pkg::lex_state_t s,
        input logic [7:0]          b,
        input logic                lst
    );
        lex_out_t r;
        logic     take_idle;
        r.nxt     = s;
        r.res     = '0;
        take_idle = 1'b0;

        if (!s.err_sink)
        begin
            unique case (s.mode)
                sst_pkg::MODE_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b) || b == sst_pkg::CH_UNDER
                        || b == sst_pkg::CH_DOT)
                    begin
                        release_held(r.nxt, r.res, 1'b0);
                        hold(r.nxt, b, sst_pkg::KIND_IDENT, 1'b0);
                    end
                    else
                    begin
                        release_held(r.nxt, r.res, 1'b1);
                        take_idle = 1'b1;
                    end
                end
                sst_pkg::MODE_NUM:
                begin
                    if (is_digit(b))
                    begin
                        release_held(r.nxt, r.res, 1'b0);
                        hold(r.nxt, b, sst_pkg::KIND_NUM, 1'b0);
                    end
                    else
                    begin
                        release_held(r.nxt, r.res, 1'b1);
                        take_idle = 1'b1;
                    end
                end
                sst_pkg::MODE_LT, sst_pkg::MODE_GT:
                begin
                    if (b == sst_pkg::CH_EQ
                        || (s.mode == sst_pkg::MODE_LT && b == sst_pkg::CH_GT))
                    begin
                        release_held(r.nxt, r.res, 1'b0);
                        put(r.res, make_tok(b, sst_pkg::KIND_CMP, 1'b0, 1'b1, 1'b0, 1'b0));
                        r.nxt.mode = sst_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        release_held(r.nxt, r.res, 1'b1);
                        take_idle = 1'b1;
                    end
                end
                sst_pkg::MODE_BANG:
                begin
                    if (b == sst_pkg::CH_EQ)
                    begin
                        release_held(r.nxt, r.res, 1'b0);
                        put(r.res, make_tok(b, sst_pkg::KIND_CMP, 1'b0, 1'b1, 1'b0, 1'b0));
                        r.nxt.mode = sst_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        raise_error(r.nxt, r.res, sst_pkg::CH_BANG, sst_pkg::ERR_UNEXPECTED);
                    end
                end
                sst_pkg::MODE_STR:
                begin
                    release_held(r.nxt, r.res, 1'b0);
                    hold(r.nxt, b, sst_pkg::KIND_STR, 1'b0);
                    if (b == sst_pkg::CH_QUOTE)
                    begin
                        r.nxt.mode = sst_pkg::MODE_STRQ;
                    end
                end
                sst_pkg::MODE_STRQ:
                begin
                    // doubled quote collapses onto the held quote
                    if (b == sst_pkg::CH_QUOTE)
                    begin
                        r.nxt.mode = sst_pkg::MODE_STR;
                    end
                    else
                    begin
                        release_held(r.nxt, r.res, 1'b1);
                        take_idle = 1'b1;
                    end
                end
                sst_pkg::MODE_IDLE:
                begin
                    take_idle = 1'b1;
                end
            endcase

            // byte starts a new token, is whitespace or raises an error
            if (take_idle)
            begin
                r.nxt.mode = sst_pkg::MODE_IDLE;
                if (!is_space(b))
                begin
                    if (r.nxt.semi_held)
                    begin
                        put(r.res, make_tok(sst_pkg::CH_SEMI, sst_pkg::KIND_PUNCT,
                                            1'b1, 1'b1, 1'b0, 1'b0));
                        r.nxt.semi_held = 1'b0;
                    end
                    priority if (b == sst_pkg::CH_SEMI)
                    begin
                        r.nxt.semi_held = 1'b1;
                    end
                    else if (b == sst_pkg::CH_LPAREN || b == sst_pkg::CH_RPAREN
                             || b == sst_pkg::CH_COMMA || b == sst_pkg::CH_STAR
                             || b == sst_pkg::CH_EQ)
                    begin
                        put(r.res, make_tok(b, sst_pkg::KIND_PUNCT, 1'b1, 1'b1, 1'b0, 1'b0));
                    end
                    else if (b == sst_pkg::CH_BANG)
                    begin
                        hold(r.nxt, b, sst_pkg::KIND_CMP, 1'b1);
                        r.nxt.mode = sst_pkg::MODE_BANG;
                    end
                    else if (b == sst_pkg::CH_LT)
                    begin
                        hold(r.nxt, b, sst_pkg::KIND_CMP, 1'b1);
                        r.nxt.mode = sst_pkg::MODE_LT;
                    end
                    else if (b == sst_pkg::CH_GT)
                    begin
                        hold(r.nxt, b, sst_pkg::KIND_CMP, 1'b1);
                        r.nxt.mode = sst_pkg::MODE_GT;
                    end
                    else if (b == sst_pkg::CH_QUOTE)
                    begin
                        hold(r.nxt, b, sst_pkg::KIND_STR, 1'b1);
                        r.nxt.mode = sst_pkg::MODE_STR;
                    end
                    else if (b == sst_pkg::CH_MINUS || is_digit(b))
                    begin
                        hold(r.nxt, b, sst_pkg::KIND_NUM, 1'b1);
                        r.nxt.mode = sst_pkg::MODE_NUM;
                    end
                    else if (is_alpha(b) || b == sst_pkg::CH_UNDER)
                    begin
                        hold(r.nxt, b, sst_pkg::KIND_IDENT, 1'b1);
                        r.nxt.mode = sst_pkg::MODE_IDENT;
                    end
                    else
                    begin
                        raise_error(r.nxt, r.res, b, sst_pkg::ERR_UNEXPECTED);
                    end
                end
            end
        end

        // statement end: close the open token or raise an error, then the end item
        if (lst)
        begin
            if (!r.nxt.err_sink)
            begin
                unique case (r.nxt.mode)
                    sst_pkg::MODE_IDENT, sst_pkg::MODE_NUM, sst_pkg::MODE_LT,
                    sst_pkg::MODE_GT, sst_pkg::MODE_STRQ:
                    begin
                        release_held(r.nxt, r.res, 1'b1);
                    end
                    sst_pkg::MODE_BANG:
                    begin
                        raise_error(r.nxt, r.res, sst_pkg::CH_BANG, sst_pkg::ERR_UNEXPECTED);
                    end
                    sst_pkg::MODE_STR:
                    begin
                        raise_error(r.nxt, r.res, sst_pkg::CH_QUOTE, sst_pkg::ERR_UNTERM);
                    end
                    sst_pkg::MODE_IDLE:
                    begin
                    end
                endcase
            end
            put(r.res, make_tok(sst_pkg::CH_NUL, sst_pkg::KIND_END, 1'b1, 1'b1, 1'b0, 1'b1));
            r.nxt = sst_pkg::LEX_RESET;
        end
        return r;
    endfunction

    // next lexer state
    always_comb
    begin : next_state_logic
        lex_out_t t;
        t       = lex_step(st_reg, byte_reg, last_reg);
        st_step = t.nxt;
    end

    // result items of the registered byte
    always_comb
    begin : output_logic
        lex_out_t t;
        t        = lex_step(st_reg, byte_reg, last_reg);
        step_res = t.res;
    end

    assign advance  = inv_reg && ((step_res.cnt == '0) || q_free);
    assign in_ready = !inv_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        st_next  = advance ? st_step : st_reg;
        inv_next = in_take ? 1'b1 : (advance ? 1'b0 : inv_reg);
    end

    always_comb
    begin
        push       = step_res;
        push.valid = advance && (step_res.cnt != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= 1'b0;
            st_reg  <= sst_pkg::LEX_RESET;
        end
        else
        begin
            inv_reg <= inv_next;
            st_reg  <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= in_byte;
            last_reg <= is_last;
        end
    end

`ifndef SYNTH
    // after an error only the end item may come out
    a_sink_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        advance && st_reg.err_sink && !last_reg |-> step_res.cnt == '0)
        else $error("result produced while discarding rest of statement");

    // every statement closes with an end item as its final result
    a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |-> step_res.cnt != '0
            && step_res.items[step_res.cnt - sst_pkg::CNT_W'(1)].done
            && step_res.items[step_res.cnt - sst_pkg::CNT_W'(1)].kind == sst_pkg::KIND_END)
        else $error("statement end without trailing end item");

    // statement end leaves nothing pending
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> st_reg.mode == sst_pkg::MODE_IDLE
            && !st_reg.held_valid && !st_reg.semi_held && !st_reg.err_sink)
        else $error("lexer state not cleared at statement end");
`endif

endmodule

// File: hdl/sst_outq.sv
// result register holding the items of one byte, drained one per cycle while out_ready is high
// depends on sst_pkg; loaded by sst_lex
module sst_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sst_pkg::tok_bundle_t push,
    output logic                 q_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           tok_byte,
    output logic [2:0]           tok_kind,
    output logic                 tok_first,
    output logic                 tok_last,
    output logic                 err_code,
    output logic                 stmt_done
);

    sst_pkg::tok_item_t [sst_pkg::MAX_RESULTS-1:0] items_reg;
    sst_pkg::tok_item_t [sst_pkg::MAX_RESULTS-1:0] items_next;
    logic [sst_pkg::CNT_W-1:0] rem_reg;
    logic [sst_pkg::CNT_W-1:0] rem_next;
    logic                      pop;

    assign out_valid = (rem_reg != '0);
    assign pop       = out_valid && out_ready;
    // empty now or emptied by this cycle's pop
    assign q_free    = (rem_reg == '0) || ((rem_reg == sst_pkg::CNT_W'(1)) && out_ready);

    always_comb
    begin
        items_next = items_reg;
        rem_next   = rem_reg;
        if (push.valid)
        begin
            items_next = push.items;
            rem_next   = push.cnt;
        end
        else if (pop)
        begin
            for (int i = 0; i < sst_pkg::MAX_RESULTS - 1; i++)
            begin
                items_next[i] = items_reg[i + 1];
            end
            rem_next = rem_reg - sst_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end

    assign tok_byte  = items_reg[0].tbyte;
    assign tok_kind  = items_reg[0].kind;
    assign tok_first = items_reg[0].first;
    assign tok_last  = items_reg[0].last;
    assign err_code  = items_reg[0].err;
    assign stmt_done = items_reg[0].done;

endmodule
